@@ src/png_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG encoder package
// Types, byte constants and the CRC-32 byte update that the encoder uses.
// ----------------------------------------------------------------------------
package png_enc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [14:0] DIM_MAX = 15'd16384;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Signature bytes.
  localparam logic [7:0] SIG_0 = 8'h89;
  localparam logic [7:0] SIG_1 = 8'h50;
  localparam logic [7:0] SIG_2 = 8'h4E;
  localparam logic [7:0] SIG_3 = 8'h47;
  localparam logic [7:0] SIG_4 = 8'h0D;
  localparam logic [7:0] SIG_5 = 8'h0A;
  localparam logic [7:0] SIG_6 = 8'h1A;
  localparam logic [7:0] SIG_7 = 8'h0A;

  // Chunk type letters.
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_N = 8'h4E;

  localparam logic [7:0] IHDR_LEN   = 8'd13;
  localparam logic [7:0] BIT_DEPTH  = 8'd8;
  localparam logic [7:0] COLOR_RGB  = 8'd2;
  localparam logic [7:0] ZLIB_CMF   = 8'h78;
  localparam logic [7:0] ZLIB_FLG   = 8'h01;

  // One accepted input byte, classified by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       first;  // first byte of an image: file header goes first
    logic       filt;   // first byte of a row: filter byte goes first
    logic       last;   // last byte of the image: trailer follows
  } item_t;

  // CRC-32 (reflected) over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/png_enc_front.sv @@
// ----------------------------------------------------------------------------
// PNG encoder front end
// Holds the image size, tracks row and column position, tags each item.
// ----------------------------------------------------------------------------
module png_enc_front import png_enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  input  logic [7:0]  pixel_byte,
  output logic        in_stall,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item,
  output logic [14:0] image_width,
  output logic [14:0] image_height
);

  logic        started;
  logic [15:0] row_byte_cnt;
  logic [13:0] row_cnt;
  logic [14:0] cfg_clamped;
  logic [16:0] row_len;
  logic        row_end;
  logic        img_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == 15'd0) begin
      cfg_clamped = 15'd1;
    end else if (cfg_data > DIM_MAX) begin
      cfg_clamped = DIM_MAX;
    end
  end

  assign row_len = {1'b0, image_width, 1'b0} + {2'b0, image_width};
  assign row_end = ({1'b0, row_byte_cnt} == row_len - 17'd1);
  assign img_end = row_end && ({1'b0, row_cnt} == image_height - 15'd1);

  always_comb begin
    q_item.data  = pixel_byte;
    q_item.first = !started;
    q_item.filt  = (row_byte_cnt == 16'd0);
    q_item.last  = img_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      row_byte_cnt <= '0;
      row_cnt      <= '0;
      image_width  <= 15'd1;
      image_height <= 15'd1;
    end else begin
      if (cfg_valid && !started) begin
        case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_clamped;
          REG_HEIGHT: image_height <= cfg_clamped;
          default: ;
        endcase
      end
      if (q_push) begin
        if (img_end) begin
          started      <= 1'b0;
          row_byte_cnt <= '0;
          row_cnt      <= '0;
        end else begin
          started <= 1'b1;
          if (row_end) begin
            row_byte_cnt <= '0;
            row_cnt      <= row_cnt + 14'd1;
          end else begin
            row_byte_cnt <= row_byte_cnt + 16'd1;
          end
        end
      end
    end
  end

endmodule

@@ src/png_enc_fifo.sv @@
// ----------------------------------------------------------------------------
// PNG encoder item queue
// A four-entry queue between the front end and the byte generator.
// ----------------------------------------------------------------------------
module png_enc_fifo import png_enc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output item_t pop_item
);

  localparam int Depth = 4;
  localparam int Aw    = $clog2(Depth);

  item_t         mem [Depth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;

  assign full     = (count == (Aw+1)'(Depth));
  assign avail    = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ src/png_enc_back.sv @@
// ----------------------------------------------------------------------------
// PNG encoder back end
// Turns queued items into file bytes: headers, stored blocks, checksums.
// ----------------------------------------------------------------------------
module png_enc_back import png_enc_pkg::*; #(
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [14:0] image_width,
  input  logic [14:0] image_height,
  input  logic        q_avail,
  input  item_t       q_item,
  output logic        q_pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        file_last,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam logic [15:0] BlkMax   = 16'(STORED_BLOCK_MAX);
  localparam logic [30:0] BlkMaxM1 = 31'(STORED_BLOCK_MAX - 1);

  // Reciprocal of the block size, exact for any 31-bit numerator.
  localparam int          BlkLog   = $clog2(STORED_BLOCK_MAX);
  localparam int          RecShift = 31 + BlkLog;
  localparam logic [32:0] RecMul   =
    33'(((64'd1 << RecShift) + 64'(STORED_BLOCK_MAX) - 64'd1) / 64'(STORED_BLOCK_MAX));

  typedef enum logic [2:0] {ST_FETCH, ST_HDR, ST_BLK, ST_DATA, ST_TAIL} state_t;
  typedef enum logic [2:0] {C_IDLE, C_MUL, C_LOAD, C_PROD, C_QUO, C_SUM} calc_t;

  state_t      state;
  logic [5:0]  idx;
  logic [7:0]  ent_byte;
  logic        ent_last;
  logic        filt_phase;
  logic [31:0] crc;
  logic [15:0] adl;
  logic [15:0] adh;
  logic [15:0] blk_cnt;
  logic [29:0] raw_rem;

  // Length unit: raw size, block count and IDAT length.
  calc_t       calc;
  logic [29:0] raw_len;
  logic [30:0] dnum;
  logic [46:0] prod_lo;
  logic [47:0] prod_hi;
  logic [63:0] prod_sum;
  logic [30:0] quo;
  logic [31:0] zlen;
  logic        zlen_ok;
  logic [31:0] mul_full;
  logic [16:0] w3p1;
  logic        calc_go;

  logic        adv;
  logic        gen_valid;
  logic [7:0]  gen_byte;
  logic        gen_crc;
  logic        gen_init;
  logic        gen_run_last;
  logic        gen_file_last;
  logic [31:0] crc_base;
  logic [31:0] crc_inv;
  logic [15:0] blk_size;
  logic        blk_final;
  logic [7:0]  data_byte;
  logic [16:0] low_sum;
  logic [15:0] low_next;
  logic [16:0] high_sum;
  logic [15:0] high_next;

  assign adv     = !out_valid || !out_stall;
  assign q_pop   = (state == ST_FETCH) && q_avail;
  assign calc_go = q_pop && q_item.first;

  assign w3p1     = {1'b0, image_width, 1'b0} + {2'b0, image_width} + 17'd1;
  assign mul_full = {17'd0, image_height} * {15'd0, w3p1};
  assign prod_sum = {prod_hi, 16'd0} + {17'd0, prod_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      calc    <= C_IDLE;
      zlen_ok <= 1'b0;
    end else begin
      case (calc)
        C_IDLE: begin
          if (calc_go) begin
            calc    <= C_MUL;
            zlen_ok <= 1'b0;
          end
        end
        C_MUL:  calc <= C_LOAD;
        C_LOAD: calc <= C_PROD;
        C_PROD: calc <= C_QUO;
        C_QUO:  calc <= C_SUM;
        C_SUM: begin
          calc    <= C_IDLE;
          zlen_ok <= 1'b1;
        end
        default: calc <= C_IDLE;
      endcase
    end
  end

  // The block count is the rounded-up quotient, taken as a product with the
  // reciprocal split into two halves so that each multiplier stays narrow.
  always_ff @(posedge clk) begin
    case (calc)
      C_MUL:  raw_len <= mul_full[29:0];
      C_LOAD: dnum <= {1'b0, raw_len} + BlkMaxM1;
      C_PROD: begin
        prod_lo <= 47'(dnum) * 47'(RecMul[15:0]);
        prod_hi <= 48'(dnum) * 48'(RecMul[32:16]);
      end
      C_QUO:  quo <= 31'(prod_sum >> RecShift);
      C_SUM:  zlen <= {2'b0, raw_len} + {quo[29:0], 2'b0} + {1'b0, quo} + 32'd6;
      default: ;
    endcase
  end

  // Stored block header fields.
  assign blk_size  = (raw_rem < {14'd0, BlkMax}) ? raw_rem[15:0] : BlkMax;
  assign blk_final = (raw_rem <= {14'd0, BlkMax});
  assign data_byte = filt_phase ? 8'd0 : ent_byte;

  // Adler-32 running sums, each reduced by one compare and subtract.
  assign low_sum   = {1'b0, adl} + {9'd0, data_byte};
  assign low_next  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
  assign high_sum  = {1'b0, adh} + {1'b0, low_next};
  assign high_next = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];

  assign crc_inv  = ~crc;
  assign crc_base = gen_init ? 32'hFFFFFFFF : crc;

  always_comb begin
    gen_valid     = 1'b0;
    gen_byte      = 8'd0;
    gen_crc       = 1'b0;
    gen_init      = 1'b0;
    gen_run_last  = 1'b0;
    gen_file_last = 1'b0;
    case (state)
      ST_HDR: begin
        gen_valid = 1'b1;
        gen_crc   = 1'b1;
        case (idx)
          6'd0:  begin gen_byte = SIG_0; gen_crc = 1'b0; end
          6'd1:  begin gen_byte = SIG_1; gen_crc = 1'b0; end
          6'd2:  begin gen_byte = SIG_2; gen_crc = 1'b0; end
          6'd3:  begin gen_byte = SIG_3; gen_crc = 1'b0; end
          6'd4:  begin gen_byte = SIG_4; gen_crc = 1'b0; end
          6'd5:  begin gen_byte = SIG_5; gen_crc = 1'b0; end
          6'd6:  begin gen_byte = SIG_6; gen_crc = 1'b0; end
          6'd7:  begin gen_byte = SIG_7; gen_crc = 1'b0; end
          6'd8, 6'd9, 6'd10: gen_crc = 1'b0;
          6'd11: begin gen_byte = IHDR_LEN; gen_crc = 1'b0; end
          6'd12: begin gen_byte = CH_I; gen_init = 1'b1; end
          6'd13: gen_byte = CH_H;
          6'd14: gen_byte = CH_D;
          6'd15: gen_byte = CH_R;
          6'd16, 6'd17, 6'd20, 6'd21: gen_byte = 8'd0;
          6'd18: gen_byte = {1'b0, image_width[14:8]};
          6'd19: gen_byte = image_width[7:0];
          6'd22: gen_byte = {1'b0, image_height[14:8]};
          6'd23: gen_byte = image_height[7:0];
          6'd24: gen_byte = BIT_DEPTH;
          6'd25: gen_byte = COLOR_RGB;
          6'd26, 6'd27, 6'd28: gen_byte = 8'd0;
          6'd29: begin gen_byte = crc_inv[31:24]; gen_crc = 1'b0; end
          6'd30: begin gen_byte = crc_inv[23:16]; gen_crc = 1'b0; end
          6'd31: begin gen_byte = crc_inv[15:8];  gen_crc = 1'b0; end
          6'd32: begin gen_byte = crc_inv[7:0];   gen_crc = 1'b0; end
          6'd33: begin gen_byte = zlen[31:24]; gen_crc = 1'b0; gen_valid = zlen_ok; end
          6'd34: begin gen_byte = zlen[23:16]; gen_crc = 1'b0; end
          6'd35: begin gen_byte = zlen[15:8];  gen_crc = 1'b0; end
          6'd36: begin gen_byte = zlen[7:0];   gen_crc = 1'b0; end
          6'd37: begin gen_byte = CH_I; gen_init = 1'b1; end
          6'd38: gen_byte = CH_D;
          6'd39: gen_byte = CH_A;
          6'd40: gen_byte = CH_T;
          6'd41: gen_byte = ZLIB_CMF;
          default: gen_byte = ZLIB_FLG;
        endcase
      end
      ST_BLK: begin
        gen_valid = 1'b1;
        gen_crc   = 1'b1;
        case (idx[2:0])
          3'd0:    gen_byte = {7'd0, blk_final};
          3'd1:    gen_byte = blk_size[7:0];
          3'd2:    gen_byte = blk_size[15:8];
          3'd3:    gen_byte = ~blk_size[7:0];
          default: gen_byte = ~blk_size[15:8];
        endcase
      end
      ST_DATA: begin
        gen_valid    = 1'b1;
        gen_crc      = 1'b1;
        gen_byte     = data_byte;
        gen_run_last = !filt_phase && !ent_last;
      end
      ST_TAIL: begin
        gen_valid = 1'b1;
        case (idx[4:0])
          5'd0:  begin gen_byte = adh[15:8]; gen_crc = 1'b1; end
          5'd1:  begin gen_byte = adh[7:0];  gen_crc = 1'b1; end
          5'd2:  begin gen_byte = adl[15:8]; gen_crc = 1'b1; end
          5'd3:  begin gen_byte = adl[7:0];  gen_crc = 1'b1; end
          5'd4, 5'd16: gen_byte = crc_inv[31:24];
          5'd5, 5'd17: gen_byte = crc_inv[23:16];
          5'd6, 5'd18: gen_byte = crc_inv[15:8];
          5'd12: begin gen_byte = CH_I; gen_crc = 1'b1; gen_init = 1'b1; end
          5'd13: begin gen_byte = CH_E; gen_crc = 1'b1; end
          5'd14: begin gen_byte = CH_N; gen_crc = 1'b1; end
          5'd15: begin gen_byte = CH_D; gen_crc = 1'b1; end
          5'd7:  gen_byte = crc_inv[7:0];
          5'd19: begin
            gen_byte      = crc_inv[7:0];
            gen_run_last  = 1'b1;
            gen_file_last = 1'b1;
          end
          default: gen_byte = 8'd0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FETCH;
      idx        <= '0;
      filt_phase <= 1'b0;
      crc        <= 32'hFFFFFFFF;
      adl        <= 16'd1;
      adh        <= '0;
      blk_cnt    <= '0;
      raw_rem    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= gen_valid;
        out_byte  <= gen_byte;
        run_last  <= gen_run_last;
        file_last <= gen_file_last;
      end
      if (q_pop) begin
        ent_byte   <= q_item.data;
        ent_last   <= q_item.last;
        filt_phase <= q_item.filt;
        idx        <= '0;
        if (q_item.first) begin
          state <= ST_HDR;
        end else begin
          state <= (blk_cnt == 16'd0) ? ST_BLK : ST_DATA;
        end
      end
      if (adv && gen_valid) begin
        if (gen_crc) begin
          crc <= crc_byte(crc_base, gen_byte);
        end
        case (state)
          ST_HDR: begin
            if (idx == 6'd42) begin
              idx     <= '0;
              raw_rem <= raw_len;
              blk_cnt <= '0;
              adl     <= 16'd1;
              adh     <= '0;
              state   <= ST_BLK;
            end else begin
              idx <= idx + 6'd1;
            end
          end
          ST_BLK: begin
            if (idx == 6'd4) begin
              idx     <= '0;
              blk_cnt <= blk_size;
              state   <= ST_DATA;
            end else begin
              idx <= idx + 6'd1;
            end
          end
          ST_DATA: begin
            adl     <= low_next;
            adh     <= high_next;
            blk_cnt <= blk_cnt - 16'd1;
            raw_rem <= raw_rem - 30'd1;
            if (filt_phase) begin
              filt_phase <= 1'b0;
              state      <= (blk_cnt == 16'd1) ? ST_BLK : ST_DATA;
            end else if (ent_last) begin
              state <= ST_TAIL;
            end else begin
              state <= ST_FETCH;
            end
          end
          ST_TAIL: begin
            if (idx == 6'd19) begin
              idx   <= '0;
              adl   <= 16'd1;
              adh   <= '0;
              crc   <= 32'hFFFFFFFF;
              state <= ST_FETCH;
            end else begin
              idx <= idx + 6'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/uncompressed_png_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// Uncompressed PNG stream encoder
// Wraps raster RGB bytes into a complete 8-bit RGB PNG file, one byte per item.
// ----------------------------------------------------------------------------
// Feed the colour bytes of an image (R, G, B per pixel, top row first) on the
// input channel and the block returns the PNG file byte by byte: signature,
// IHDR, one IDAT chunk holding a zlib stream of stored deflate blocks, and
// IEND. Set image_width (index 0) and image_height (index 1) between images;
// writes while an image is in progress are ignored, zero is taken as 1 and
// values above 16384 as 16384. Every output byte carries run_last, which marks
// the last byte caused by an input item, and file_last, which marks the end of
// the file. The front end tags each item and pushes it into a four-entry
// queue; the back end emits at most one file byte per cycle when the output
// is free. For an ordinary pixel byte the back end takes the item from the
// queue, then sends its byte; the first byte of a row also sends the filter
// byte, every stored block adds five header bytes, the first item of an
// image adds 43 header bytes and the last item adds 20 trailer bytes. The
// IDAT length is worked out by a multiplier and a multiplication by the
// reciprocal of the block size, starting with the first item, which is done
// long before the header reaches the length field, so it never holds the
// header.
// ----------------------------------------------------------------------------
module uncompressed_png_stream_encoder import png_enc_pkg::*; #(
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        file_last
);

  logic        q_full;
  logic        q_push;
  item_t       q_in;
  logic        q_pop;
  logic        q_avail;
  item_t       q_out;
  logic [14:0] image_width;
  logic [14:0] image_height;

  // Front end: image size registers, row and column tracking.
  png_enc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .pixel_byte   (pixel_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Queue lets the input keep flowing while the back end sends header bytes.
  png_enc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_item  (q_out)
  );

  // Back end: byte sequencer, CRC-32, Adler-32 and the output register.
  png_enc_back #(
    .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .q_avail      (q_avail),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .file_last    (file_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

@@ verif/uncompressed_png_stream_encoder_test.sv @@
// ----------------------------------------------------------------------------
// Uncompressed PNG stream encoder testbench
// Streams raster RGB items into the encoder and checks every output byte
// against a cycle-free model of the PNG file it should produce.
// ----------------------------------------------------------------------------
// The testbench predicts the whole file: signature, IHDR, the IDAT chunk with
// its zlib header, stored-block headers, filter bytes, Adler-32 and CRC-32,
// and IEND. Each accepted input item appends its expected bytes, with the
// run_last and file_last flags, to a queue, and a checker compares each
// accepted output byte with the oldest entry. Images run with directed and
// random sizes, including zero-size writes that clamp to one and writes to
// the spare register indexes.
// ----------------------------------------------------------------------------
module uncompressed_png_stream_encoder_test import png_enc_pkg::*;;

  localparam int BLOCK_MAX = 65535;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } png_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        file_last;

  uncompressed_png_stream_encoder u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_byte(pixel_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .run_last(run_last), .file_last(file_last)
  );

  always #6 clk = ~clk;

  // Predicted encoder state: the registers and the running stream counters.
  logic [14:0] pred_width, pred_height;
  int unsigned row_pos, block_left, raw_left, adler_lo, adler_hi;
  logic [31:0] chunk_crc;
  bit          image_open;

  png_byte_t   file_expect[$];
  logic [7:0]  item_bytes[$];

  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int images_done = 0;

  // Idling controls: set by the test sequence, read by the drivers; burst_left is the sender's own.
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_epoch = 0;
  int burst_left = 0;

  // Appends one file byte, folding it into the chunk CRC when asked.
  task automatic emit(input logic [7:0] b, input bit in_crc);
    logic [31:0] c;
    if (in_crc) begin
      c = chunk_crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      chunk_crc = c;
    end
    item_bytes.insert(item_bytes.size(), b);
  endtask

  task automatic emit_be32(input logic [31:0] v, input bit in_crc);
    for (int s = 24; s >= 0; s -= 8) emit(v[s +: 8], in_crc);
  endtask

  task automatic open_chunk(input logic [31:0] len, input logic [7:0] t0, input logic [7:0] t1,
                            input logic [7:0] t2, input logic [7:0] t3);
    emit_be32(len, 1'b0);
    chunk_crc = 32'hFFFF_FFFF;
    emit(t0, 1'b1);
    emit(t1, 1'b1);
    emit(t2, 1'b1);
    emit(t3, 1'b1);
  endtask

  task automatic close_chunk();
    emit_be32(~chunk_crc, 1'b0);
    chunk_crc = 32'hFFFF_FFFF;
  endtask

  // One byte of the raw zlib payload; opens a stored block when needed.
  task automatic stream_raw(input logic [7:0] b);
    int unsigned size;
    logic [15:0] nlen;
    if (raw_left == 0) return;
    if (block_left == 0) begin
      size = (raw_left < BLOCK_MAX) ? raw_left : BLOCK_MAX;
      nlen = ~size[15:0];
      emit((size == raw_left) ? 8'h01 : 8'h00, 1'b1);
      emit(size[7:0], 1'b1);
      emit(size[15:8], 1'b1);
      emit(nlen[7:0], 1'b1);
      emit(nlen[15:8], 1'b1);
      block_left = size;
    end
    adler_lo = (adler_lo + b) % 65521;
    adler_hi = (adler_hi + adler_lo) % 65521;
    emit(b, 1'b1);
    block_left--;
    raw_left--;
  endtask

  task automatic start_file();
    longint unsigned raw_len, blocks;
    logic [31:0] zlen;
    raw_len = longint'(pred_height) * (longint'(pred_width) * 3 + 1);
    blocks = (raw_len + BLOCK_MAX - 1) / BLOCK_MAX;
    zlen = 32'(2 + 5 * blocks + raw_len + 4);
    emit(SIG_0, 1'b0); emit(SIG_1, 1'b0); emit(SIG_2, 1'b0); emit(SIG_3, 1'b0);
    emit(SIG_4, 1'b0); emit(SIG_5, 1'b0); emit(SIG_6, 1'b0); emit(SIG_7, 1'b0);
    open_chunk({24'd0, IHDR_LEN}, CH_I, CH_H, CH_D, CH_R);
    emit_be32({17'd0, pred_width}, 1'b1);
    emit_be32({17'd0, pred_height}, 1'b1);
    emit(BIT_DEPTH, 1'b1);
    emit(COLOR_RGB, 1'b1);
    emit(8'd0, 1'b1);
    emit(8'd0, 1'b1);
    emit(8'd0, 1'b1);
    close_chunk();
    open_chunk(zlen, CH_I, CH_D, CH_A, CH_T);
    emit(ZLIB_CMF, 1'b1);
    emit(ZLIB_FLG, 1'b1);
    raw_left = 32'(raw_len);
    block_left = 0;
    row_pos = 0;
    adler_lo = 1;
    adler_hi = 0;
    image_open = 1'b1;
  endtask

  task automatic clear_stream();
    row_pos = 0;
    block_left = 0;
    raw_left = 0;
    adler_lo = 1;
    adler_hi = 0;
    chunk_crc = 32'hFFFF_FFFF;
    image_open = 1'b0;
  endtask

  // Works out every file byte that one accepted pixel item causes.
  task automatic predict_pixel(input logic [7:0] px);
    bit ended;
    png_byte_t e;
    ended = 1'b0;
    item_bytes.delete();
    if (!image_open) start_file();
    if (row_pos == 0) stream_raw(8'd0);
    stream_raw(px);
    row_pos++;
    if (row_pos >= pred_width * 3) row_pos = 0;
    if (raw_left == 0) begin
      emit(adler_hi[15:8], 1'b1);
      emit(adler_hi[7:0], 1'b1);
      emit(adler_lo[15:8], 1'b1);
      emit(adler_lo[7:0], 1'b1);
      close_chunk();
      open_chunk(32'd0, CH_I, CH_E, CH_N, CH_D);
      close_chunk();
      clear_stream();
      ended = 1'b1;
    end
    foreach (item_bytes[k]) begin
      e.data = item_bytes[k];
      e.run_end = (k == item_bytes.size() - 1);
      e.file_end = e.run_end && ended;
      file_expect.insert(file_expect.size(), e);
    end
  endtask

  task automatic predict_register(input logic [1:0] idx, input logic [14:0] v);
    logic [14:0] d;
    if (image_open) return;
    d = (v == 0) ? 15'd1 : ((v > DIM_MAX) ? DIM_MAX : v);
    if (idx == REG_WIDTH) pred_width = d;
    else if (idx == REG_HEIGHT) pred_height = d;
  endtask

  // Output checker: compares each accepted byte with the oldest expectation.
  always @(posedge clk) begin
    png_byte_t e;
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (file_expect.size() == 0) begin
        errors++;
        $display("%0t: out_byte expected none actual %02h (run_last %0b file_last %0b)",
                 $time, out_byte, run_last, file_last);
      end else begin
        e = file_expect.pop_front();
        if (out_byte !== e.data) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, e.data, out_byte);
        end
        if (run_last !== e.run_end) begin
          errors++;
          $display("%0t: run_last expected %0b actual %0b", $time, e.run_end, run_last);
        end
        if (file_last !== e.file_end) begin
          errors++;
          $display("%0t: file_last expected %0b actual %0b", $time, e.file_end, file_last);
        end
      end
    end
  end

  // Receiver: random stalls at the current rate, plus a long hold-off each
  // time the test sequence bumps hold_epoch.
  int seen_epoch = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (seen_epoch != hold_epoch) begin
      seen_epoch = hold_epoch;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, file_expect.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one pixel item; after it the sender may pause between bursts.
  task automatic send_pixel(input logic [7:0] px);
    in_valid <= 1'b1;
    pixel_byte <= px;
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    predict_register(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Lets the block drain completely before the next register write.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (file_expect.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Sends one whole image. Pattern 0 is random, 1 alternates the extremes.
  task automatic send_image(input int pattern);
    int n;
    n = pred_width * pred_height * 3;
    for (int i = 0; i < n; i++) begin
      if (pattern == 1) send_pixel((i % 2) ? 8'hFF : 8'h00);
      else send_pixel(8'($urandom));
    end
    images_done++;
  endtask

  // Reset values: a 1x1 image with extreme and middle byte values.
  task automatic test_reset_sizes();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h80);
    images_done++;
    wait_drained();
  endtask

  // Zero writes clamp to one; the spare indexes are ignored.
  task automatic test_register_limits();
    write_register(REG_WIDTH, 15'd0);
    write_register(REG_HEIGHT, 15'd0);
    write_register(REG_SPARE_2, 15'd5);
    write_register(REG_SPARE_3, 15'd7);
    send_gap_pct = 10;
    stall_pct = 10;
    send_image(0);
    wait_drained();
  endtask

  // An oversize write replaced by a later one, then one long row.
  task automatic test_widest_row();
    write_register(REG_WIDTH, 15'd20000);
    write_register(REG_WIDTH, 15'd40);
    write_register(REG_HEIGHT, 15'd1);
    send_gap_pct = 0;
    stall_pct = 0;
    send_image(1);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    write_register(REG_WIDTH, 15'd4);
    write_register(REG_HEIGHT, 15'd3);
    send_gap_pct = 0;
    stall_pct = 0;
    hold_epoch++;
    send_image(1);
    wait_drained();
  endtask

  // Random small images with changing idling on both sides.
  task automatic test_random_images();
    int start_items;
    start_items = items_sent;
    while (items_sent - start_items < 180) begin
      write_register(REG_WIDTH, 15'($urandom_range(1, 6)));
      write_register(REG_HEIGHT, 15'($urandom_range(1, 5)));
      send_gap_pct = $urandom_range(0, 3) * 25;
      stall_pct = $urandom_range(0, 3) * 20;
      send_image(0);
      wait_drained();
    end
  endtask

  initial begin
    pred_width = 15'd1;
    pred_height = 15'd1;
    clear_stream();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_sizes();
    test_backpressure();
    test_register_limits();
    test_widest_row();
    test_random_images();
    wait_drained();
    if (file_expect.size() != 0) errors++;
    $display("Covered %0d images from %0d pixel items, %0d file bytes checked,",
             images_done, items_sent, bytes_checked);
    $display("including zero-size clamping, spare indexes, a long row and a long hold-off.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/png_enc_pkg.sv
src/png_enc_front.sv
src/png_enc_fifo.sv
src/png_enc_back.sv
src/uncompressed_png_stream_encoder.sv
verif/uncompressed_png_stream_encoder_test.sv
